// ===== hw/rtl/vcmq_pkg.sv =====
package vcmq_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 22;
  localparam int unsigned SumWidth = 22;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_FILTER_WIDTH  = 3'd2,
    REG_FILTER_HEIGHT = 3'd3,
    REG_CLAMP_LOW     = 3'd4,
    REG_CLAMP_HIGH    = 3'd5
  } reg_index_t;

  localparam logic [CfgIndexWidth-1:0] FirstClampReg = 3'd4;
  localparam logic [7:0] FullScale = 8'd255;

  // Window product row handed along the cell chain
  typedef struct packed {
    logic [SumWidth-1:0] sum;
  } cell_data_t;

endpackage

// ===== hw/rtl/vcmq_if.sv =====
interface vcmq_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] pixel_value;
  modport source (output valid, mode, pixel_value, input ready);
  modport sink (input valid, mode, pixel_value, output ready);
endinterface

interface vcmq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_pixel;
  logic       last_of_image;
  logic       size_error;
  modport source (output valid, out_pixel, last_of_image, size_error, input ready);
  modport sink (input valid, out_pixel, last_of_image, size_error, output ready);
endinterface

interface vcmq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [21:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/valid_convolution_minmax_quantize_unit.sv =====
// Valid 2-D convolution with min/max requantization.
// Channels: in_ch (mode, pixel_value), out_ch (out_pixel, last_of_image,
// size_error), cfg_ch (index, data). Mode 0 items load filter weights in
// raster order; mode 1 items are image pixels in raster order. A result
// appears for each pixel that completes a full filter window, or for each
// pixel when the filter exceeds the image (size_error set).
// Per pixel the window sum is built row by row: each filter row is fetched
// one tap per cycle into a chain of MAX_FILTER_SIZE multiply-accumulate cells
// and then drained down the chain into the accumulator. An in-range sum
// then goes through a restoring divider. A new pixel item is taken only
// once the previous one is finished and the unit is back in idle; weight
// items are taken in idle without leaving it.
// Finished results pass through a holding register to the output register,
// so a stalled result does not block the next pixel; the input stalls while
// the holding register is occupied. Config writes are taken only while idle.
// Reset restores register defaults and clears the position counters;
// weights and row buffer are undefined until written.
module valid_convolution_minmax_quantize_unit #(
  parameter int unsigned MAX_IMAGE_WIDTH  = 64,
  parameter int unsigned MAX_IMAGE_HEIGHT = 64,
  parameter int unsigned MAX_FILTER_SIZE  = 8
) (
  input logic       clk,
  input logic       rst,
  vcmq_in_if.sink   in_ch,
  vcmq_out_if.source out_ch,
  vcmq_cfg_if.sink  cfg_ch
);
  localparam int unsigned CW = $clog2(MAX_IMAGE_WIDTH);
  localparam int unsigned RW = $clog2(MAX_IMAGE_HEIGHT);
  localparam int unsigned FW = $clog2(MAX_FILTER_SIZE + 1);
  localparam int unsigned FR = (MAX_FILTER_SIZE > 1) ? $clog2(MAX_FILTER_SIZE) : 1;
  localparam int unsigned WD = MAX_FILTER_SIZE * MAX_FILTER_SIZE;
  localparam int unsigned WI = (WD > 1) ? $clog2(WD) : 1;
  localparam int unsigned SD = MAX_FILTER_SIZE * MAX_IMAGE_WIDTH;
  localparam int unsigned SI = $clog2(SD);
  localparam int unsigned N  = MAX_FILTER_SIZE;

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_FILL, S_DRAIN, S_QUANT, S_DIV, S_OUT
  } state_t;

  // configuration registers
  logic [6:0]  image_width, image_height;
  logic [3:0]  filter_width, filter_height;
  logic [21:0] clamp_low, clamp_high;

  logic [CW:0] iw;
  logic [RW:0] ih;
  logic [FW-1:0] fw, fh;

  always_comb begin
    iw = (image_width == 7'd0) ? (CW+1)'(1) :
         ({25'd0, image_width} > MAX_IMAGE_WIDTH) ? (CW+1)'(MAX_IMAGE_WIDTH) :
         (CW+1)'(image_width);
    ih = (image_height == 7'd0) ? (RW+1)'(1) :
         ({25'd0, image_height} > MAX_IMAGE_HEIGHT) ? (RW+1)'(MAX_IMAGE_HEIGHT) :
         (RW+1)'(image_height);
    fw = (filter_width == 4'd0) ? FW'(1) :
         ({28'd0, filter_width} > MAX_FILTER_SIZE) ? FW'(MAX_FILTER_SIZE) :
         FW'(filter_width);
    fh = (filter_height == 4'd0) ? FW'(1) :
         ({28'd0, filter_height} > MAX_FILTER_SIZE) ? FW'(MAX_FILTER_SIZE) :
         FW'(filter_height);
  end

  state_t state;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [WI:0]   widx;
  logic [FW-1:0] yy;
  logic [FW-1:0] xx;
  logic [FW-1:0] drain;
  logic [21:0]   acc;
  logic          last_q;

  // finished result waiting for the output register
  logic       res_valid;
  logic [7:0] res_pixel;
  logic       res_last;
  logic       res_err;

  logic in_acc, cfg_acc, size_bad, win_ok;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = (state == S_IDLE);
  assign in_ch.ready  = (state == S_IDLE) && !res_valid && !cfg_ch.valid;
  assign size_bad = ({{(CW+1-FW){1'b0}}, fw} > iw) || ({{(RW+1-FW){1'b0}}, fh} > ih);
  assign win_ok   = ({1'b0, col} + (CW+1)'(1) >= {{(CW+1-FW){1'b0}}, fw}) &&
                    ({1'b0, row} + (RW+1)'(1) >= {{(RW+1-FW){1'b0}}, fh});

  // memories
  logic [7:0] wmem [WD];
  logic [7:0] smem [SD];
  logic [WI-1:0] w_raddr;
  logic [SI-1:0] s_raddr;
  logic [7:0] w_rd, s_rd;
  logic rd_en;

  // current window row and column being fetched
  logic [RW:0] win_row;
  logic [CW:0] win_col;
  assign win_row = {1'b0, row} + (RW+1)'(1) - {{(RW+1-FW){1'b0}}, fh} + {{(RW+1-FW){1'b0}}, yy};
  assign win_col = {1'b0, col} + (CW+1)'(1) - {{(CW+1-FW){1'b0}}, fw} + {{(CW+1-FW){1'b0}}, xx};
  assign w_raddr = WI'({{(WI+1-FW){1'b0}}, yy} * {{(WI+1-FW){1'b0}}, fw} +
                       {{(WI+1-FW){1'b0}}, xx});
  assign s_raddr = SI'({win_row[FR-1:0], win_col[CW-1:0]});
  assign rd_en   = (state == S_ROW);

  always_ff @(posedge clk) begin
    if (in_acc && !in_ch.mode && widx < (WI+1)'(WD)) wmem[widx[WI-1:0]] <= in_ch.pixel_value;
    if (in_acc && in_ch.mode) smem[SI'({row[FR-1:0], col})] <= in_ch.pixel_value;
    if (rd_en) begin
      w_rd <= wmem[w_raddr];
      s_rd <= smem[s_raddr];
    end
  end

  // cell chain: fetched row pixels shift in, then each cell multiplies its tap
  logic [7:0] px_sh [N];
  logic [7:0] wt_sh [N];
  logic       act_sh [N];
  logic       fill_v;
  logic       chain_en;
  vcmq_pkg::cell_data_t link [N+1];
  assign link[0].sum = '0;
  assign chain_en = (state == S_DRAIN);

  always_ff @(posedge clk) begin
    if (fill_v) begin
      px_sh[0]  <= s_rd;
      wt_sh[0]  <= w_rd;
      act_sh[0] <= 1'b1;
      for (int i = 1; i < N; i++) begin
        px_sh[i] <= px_sh[i-1];
        wt_sh[i] <= wt_sh[i-1];
        act_sh[i] <= act_sh[i-1];
      end
    end else if (state == S_ROW && xx == '0) begin
      for (int i = 0; i < N; i++) act_sh[i] <= 1'b0;
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      vcmq_cell u_cell (
        .clk    (clk),
        .en     (chain_en),
        .pixel  (px_sh[g]),
        .weight (wt_sh[g]),
        .active (act_sh[g]),
        .sum_in (link[g]),
        .sum_out(link[g+1])
      );
    end
  endgenerate

  // divider
  logic        div_start, div_busy, div_done;
  logic [7:0]  div_q;
  logic [29:0] div_num;
  logic [21:0] div_den;
  vcmq_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_q)
  );
  assign div_num = ({8'd0, acc - clamp_low} << 8) - {8'd0, acc - clamp_low};
  assign div_den = clamp_high - clamp_low;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      image_width <= 7'd28; image_height <= 7'd28;
      filter_width <= 4'd5; filter_height <= 4'd5;
      clamp_low <= '0; clamp_high <= 22'h3FFFFF;
      col <= '0; row <= '0; widx <= '0;
      res_valid <= 1'b0;
      fill_v <= 1'b0;
      div_start <= 1'b0;
    end else begin
      fill_v <= 1'b0;
      div_start <= 1'b0;
      if (res_valid && (!out_ch.valid || out_ch.ready)) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            unique case (cfg_ch.index)
              vcmq_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_ch.data[6:0];
              vcmq_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_ch.data[6:0];
              vcmq_pkg::REG_FILTER_WIDTH:  filter_width  <= cfg_ch.data[3:0];
              vcmq_pkg::REG_FILTER_HEIGHT: filter_height <= cfg_ch.data[3:0];
              vcmq_pkg::REG_CLAMP_LOW:     clamp_low     <= cfg_ch.data;
              vcmq_pkg::REG_CLAMP_HIGH:    clamp_high    <= cfg_ch.data;
              default: ;
            endcase
            if (cfg_ch.index < vcmq_pkg::FirstClampReg) begin
              col <= '0; row <= '0; widx <= '0;
            end
          end else if (in_acc) begin
            if (!in_ch.mode) begin
              if (widx + (WI+1)'(1) >= ({{(WI+1-FW){1'b0}}, fw} * {{(WI+1-FW){1'b0}}, fh}))
                widx <= '0;
              else widx <= widx + (WI+1)'(1);
            end else begin
              last_q <= ({1'b0, col} + (CW+1)'(1) == iw) &&
                        ({1'b0, row} + (RW+1)'(1) == ih);
              if (size_bad) begin
                res_pixel <= '0;
                res_err <= 1'b1;
                res_last <= ({1'b0, col} + (CW+1)'(1) == iw) &&
                            ({1'b0, row} + (RW+1)'(1) == ih);
                res_valid <= 1'b1;
                state <= S_OUT;
              end else if (win_ok) begin
                yy <= '0; xx <= '0; acc <= '0;
                state <= S_ROW;
              end else begin
                state <= S_OUT;
              end
            end
          end
        end
        // fetch one window row, one tap per cycle (read data lands next cycle)
        S_ROW: begin
          fill_v <= 1'b1;
          if (xx + FW'(1) == fw) begin
            state <= S_FILL;
          end else begin
            xx <= xx + FW'(1);
          end
        end
        // last fetched tap shifts in; taps beyond fw stay idle
        S_FILL: begin
          drain <= '0;
          state <= S_DRAIN;
        end
        // partial sum ripples down the cell chain
        S_DRAIN: begin
          drain <= drain + FW'(1);
          if (drain == FW'(N)) begin
            acc <= acc + link[N].sum;
            xx <= '0;
            if (yy + FW'(1) == fh) state <= S_QUANT;
            else begin
              yy <= yy + FW'(1);
              state <= S_ROW;
            end
          end
        end
        S_QUANT: begin
          res_err <= 1'b0;
          res_last <= last_q;
          if (acc < clamp_low) begin
            res_pixel <= '0; res_valid <= 1'b1; state <= S_OUT;
          end else if (acc > clamp_high) begin
            res_pixel <= vcmq_pkg::FullScale; res_valid <= 1'b1; state <= S_OUT;
          end else if (clamp_high == clamp_low) begin
            res_pixel <= '0; res_valid <= 1'b1; state <= S_OUT;
          end else begin
            div_start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_pixel <= div_q;
            res_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        // advance position once the item is done
        S_OUT: begin
          if ({1'b0, col} + (CW+1)'(1) >= iw) begin
            col <= '0;
            if ({1'b0, row} + (RW+1)'(1) >= ih) row <= '0;
            else row <= row + RW'(1);
          end else begin
            col <= col + CW'(1);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: takes the held result once the receiver has room
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (!out_ch.valid || out_ch.ready) begin
      out_ch.valid <= res_valid;
      if (res_valid) begin
        out_ch.out_pixel     <= res_pixel;
        out_ch.last_of_image <= res_last;
        out_ch.size_error    <= res_err;
      end
    end
  end

  // the drain must wait for a full chain and the shifts to be still
  a_drain_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> !fill_v) else $error("fill during drain");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV && !div_busy) else $error("divider done outside divide");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
endmodule

// ===== hw/rtl/vcmq_cell.sv =====
// One multiply-accumulate cell: adds pixel * weight (zero when not active) to the partial
// sum arriving from its left neighbor and registers the result while enabled.
module vcmq_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [7:0]                     pixel,
  input  logic [7:0]                     weight,
  input  logic                           active,
  input  vcmq_pkg::cell_data_t           sum_in,
  output vcmq_pkg::cell_data_t           sum_out
);
  logic [15:0] prod;
  assign prod = active ? pixel * weight : 16'd0;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_out.sum <= sum_in.sum + vcmq_pkg::SumWidth'(prod);
    end
  end
endmodule

// ===== hw/rtl/vcmq_divider.sv =====
// Restoring divider, one quotient bit per cycle: q = num / den
module vcmq_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [29:0] num,
  input  logic [21:0] den,
  output logic        busy,
  output logic        done,
  output logic [7:0]  quo
);
  logic [29:0] rem;
  logic [29:0] dsr;
  logic [4:0]  cnt;
  logic [30:0] trial;

  // quotient is at most 255, so only 8 bits are searched
  assign trial = {1'b0, rem} - ({1'b0, dsr} << cnt[2:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= num;
        dsr  <= {8'd0, den};
        cnt  <= 5'd7;
        quo  <= '0;
      end else if (busy) begin
        if (!trial[30]) begin
          rem <= trial[29:0];
          quo[cnt[2:0]] <= 1'b1;
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end
endmodule

// ===== sim/vcmq_scoreboard.sv =====
`timescale 1ns / 100ps

module vcmq_scoreboard (
  input  logic clk,
  input  logic rst,
  vcmq_in_if   in_ch,
  vcmq_out_if  out_ch,
  vcmq_cfg_if  cfg_ch,
  output int   fails,
  output int   pending
);

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       last_of_image;
    logic       size_error;
  } conv_result_t;

  conv_result_t result_q[$];

  // Mirrored registers and position
  logic [6:0]  img_w_reg, img_h_reg;
  logic [3:0]  flt_w_reg, flt_h_reg;
  logic [21:0] lo_reg, hi_reg;
  logic [7:0]  weights [64];
  logic [7:0]  rows [512];
  int unsigned col_pos, row_pos, wt_pos;

  function automatic int unsigned clip_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [7:0] requantize(longint unsigned s);
    longint unsigned lo, hi;
    lo = lo_reg;
    hi = hi_reg;
    if (s < lo) return 8'd0;
    if (s > hi) return vcmq_pkg::FullScale;
    if (hi == lo) return 8'd0;
    return 8'(((s - lo) * 255) / (hi - lo));
  endfunction

  // Window sum and position update for one accepted item
  task automatic predict_window(logic mode, logic [7:0] val);
    int unsigned iw, ih, fw, fh, rr, cc;
    longint unsigned s;
    conv_result_t res;
    iw = clip_size(img_w_reg, 64);
    ih = clip_size(img_h_reg, 64);
    fw = clip_size(flt_w_reg, 8);
    fh = clip_size(flt_h_reg, 8);
    if (!mode) begin
      weights[wt_pos] = val;
      wt_pos++;
      if (wt_pos >= fw * fh) wt_pos = 0;
      return;
    end
    rows[(row_pos % 8) * 64 + col_pos] = val;
    res.last_of_image = (col_pos + 1 == iw) && (row_pos + 1 == ih);
    if (fw > iw || fh > ih) begin
      res.out_pixel = 8'd0;
      res.size_error = 1'b1;
      result_q.push_back(res);
    end else if (col_pos + 1 >= fw && row_pos + 1 >= fh) begin
      s = 0;
      for (int y = 0; y < fh; y++) begin
        rr = row_pos + 1 - fh + y;
        for (int x = 0; x < fw; x++) begin
          cc = col_pos + 1 - fw + x;
          s += longint'(rows[(rr % 8) * 64 + cc]) * longint'(weights[y * fw + x]);
        end
      end
      res.out_pixel = requantize(s);
      res.size_error = 1'b0;
      result_q.push_back(res);
    end
    col_pos++;
    if (col_pos >= iw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ih) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    conv_result_t exp_res;
    if (rst) begin
      img_w_reg <= 7'd28;
      img_h_reg <= 7'd28;
      flt_w_reg <= 4'd5;
      flt_h_reg <= 4'd5;
      lo_reg    <= '0;
      hi_reg    <= '1;
      col_pos = 0;
      row_pos = 0;
      wt_pos  = 0;
      fails   = 0;
    end else begin
      // Register writes (only while idle)
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (vcmq_pkg::reg_index_t'(cfg_ch.index))
          vcmq_pkg::REG_IMAGE_WIDTH:   img_w_reg <= cfg_ch.data[6:0];
          vcmq_pkg::REG_IMAGE_HEIGHT:  img_h_reg <= cfg_ch.data[6:0];
          vcmq_pkg::REG_FILTER_WIDTH:  flt_w_reg <= cfg_ch.data[3:0];
          vcmq_pkg::REG_FILTER_HEIGHT: flt_h_reg <= cfg_ch.data[3:0];
          vcmq_pkg::REG_CLAMP_LOW:     lo_reg    <= cfg_ch.data;
          vcmq_pkg::REG_CLAMP_HIGH:    hi_reg    <= cfg_ch.data;
          default: ;
        endcase
        if (cfg_ch.index < vcmq_pkg::FirstClampReg) begin
          col_pos = 0;
          row_pos = 0;
          wt_pos  = 0;
        end
      end
      if (in_ch.valid && in_ch.ready) predict_window(in_ch.mode, in_ch.pixel_value);
      // Compare against oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: out_pixel %0d", out_ch.out_pixel);
          fails++;
        end else begin
          exp_res = result_q.pop_front();
          if (out_ch.out_pixel !== exp_res.out_pixel) begin
            $error("out_pixel: expected %0d, got %0d", exp_res.out_pixel, out_ch.out_pixel);
            fails++;
          end
          if (out_ch.last_of_image !== exp_res.last_of_image) begin
            $error("last_of_image: expected %0b, got %0b", exp_res.last_of_image,
                   out_ch.last_of_image);
            fails++;
          end
          if (out_ch.size_error !== exp_res.size_error) begin
            $error("size_error: expected %0b, got %0b", exp_res.size_error,
                   out_ch.size_error);
            fails++;
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== sim/tb_valid_convolution_minmax_quantize_unit.sv =====
`timescale 1ns / 100ps

module tb_valid_convolution_minmax_quantize_unit;

  logic clk;
  logic rst;
  int   fails, pending;
  int   in_idle_pct, out_stall_pct;
  int   hold_req, hold_seen, hold_left;
  int   items_sent;

  vcmq_in_if  in_ch ();
  vcmq_out_if out_ch ();
  vcmq_cfg_if cfg_ch ();

  valid_convolution_minmax_quantize_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  vcmq_scoreboard scoreboard (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic send_item(logic mode, logic [7:0] val);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.pixel_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic quiet_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all expected results, then for any work without a result
  task automatic drain();
    int n;
    n = 0;
    while (pending != 0) begin
      @(posedge clk);
      n++;
      if (n > 200_000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(vcmq_pkg::reg_index_t idx, logic [21:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int iw, int ih, int fw, int fh, logic [21:0] lo,
                              logic [21:0] hi);
    write_reg(vcmq_pkg::REG_IMAGE_WIDTH, 22'(iw));
    write_reg(vcmq_pkg::REG_IMAGE_HEIGHT, 22'(ih));
    write_reg(vcmq_pkg::REG_FILTER_WIDTH, 22'(fw));
    write_reg(vcmq_pkg::REG_FILTER_HEIGHT, 22'(fh));
    write_reg(vcmq_pkg::REG_CLAMP_LOW, lo);
    write_reg(vcmq_pkg::REG_CLAMP_HIGH, hi);
  endtask

  function automatic int eff(int v, int maxv);
    return (v == 0) ? 1 : (v > maxv) ? maxv : v;
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // One random configuration, filter load and one or two images
  task automatic run_phase(int iw, int ih, int fw, int fh);
    int nw, ew, eh;
    int maxsum;
    logic [21:0] lo, hi;
    ew = eff(fw, 8);
    eh = eff(fh, 8);
    nw = ew * eh;
    maxsum = nw * 255 * 255;
    case ($urandom_range(5))
      0: begin lo = '0; hi = '1; end
      1: begin lo = 22'($urandom_range(0, 200)); hi = lo; end
      2: begin lo = 22'($urandom_range(0, maxsum)); hi = 22'($urandom_range(0, lo)); end
      default: begin
        lo = 22'($urandom_range(0, maxsum / 2));
        hi = 22'(lo + $urandom_range(1, maxsum / 2 + 1));
      end
    endcase
    set_geometry(iw, ih, fw, fh, lo, hi);
    for (int i = 0; i < nw; i++) send_item(1'b0, rand_pixel());
    repeat ($urandom_range(1, 2)) begin
      for (int p = 0; p < eff(iw, 64) * eff(ih, 64); p++) begin
        // stray weight overwrite as noise
        if ($urandom_range(99) < 3) send_item(1'b0, rand_pixel());
        send_item(1'b1, rand_pixel());
      end
    end
    quiet_input();
    drain();
  endtask

  initial begin
    int phase, iw, ih, fw, fh;
    int idle_tab[4], stall_tab[4];
    idle_tab  = '{0, 48, 0, 20};
    stall_tab = '{0, 0, 48, 20};
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.pixel_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 3x3 image, 2x2 filter with extreme weights
    set_geometry(3, 3, 2, 2, 22'd0, 22'h3FFFFF);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd0);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'd128);
    for (int i = 0; i < 9; i++) send_item(1'b1, (i % 2) ? 8'd0 : 8'd255);
    quiet_input();
    drain();
    // Filter larger than image
    set_geometry(2, 1, 3, 3, 22'd0, 22'd0);
    send_item(1'b1, 8'd17);
    send_item(1'b1, 8'd200);
    quiet_input();
    drain();
    // Zero-size registers read as one; equal bounds
    set_geometry(0, 0, 0, 0, 22'd5, 22'd5);
    send_item(1'b0, 8'd1);
    send_item(1'b1, 8'd5);
    send_item(1'b1, 8'd4);
    quiet_input();
    drain();

    // Oversized registers, extreme geometries, each under its own idle setting
    phase = 0;
    in_idle_pct   = idle_tab[phase % 4];
    out_stall_pct = stall_tab[phase % 4];
    run_phase(127, 1, 15, 0);
    phase++;
    in_idle_pct   = idle_tab[phase % 4];
    out_stall_pct = stall_tab[phase % 4];
    run_phase(1, 127, 1, 1);
    phase++;
    in_idle_pct   = idle_tab[phase % 4];
    out_stall_pct = stall_tab[phase % 4];
    run_phase(9, 8, 8, 8);
    phase++;

    // Backpressure: hold receiver while the sender keeps pushing
    in_idle_pct   = 0;
    out_stall_pct = 0;
    set_geometry(6, 6, 2, 2, 22'd0, 22'd60000);
    for (int i = 0; i < 4; i++) send_item(1'b0, rand_pixel());
    hold_req <= hold_req + 1;
    for (int i = 0; i < 36; i++) send_item(1'b1, rand_pixel());
    quiet_input();
    drain();

    // Random phases, cycling through idle settings
    while (items_sent < 480) begin
      in_idle_pct   = idle_tab[phase % 4];
      out_stall_pct = stall_tab[phase % 4];
      iw = $urandom_range(1, 10);
      ih = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) begin
        fw = $urandom_range(1, 8);
        fh = $urandom_range(1, 8);
      end else begin
        fw = $urandom_range(1, (iw < 4) ? iw : 4);
        fh = $urandom_range(1, (ih < 4) ? ih : 4);
      end
      run_phase(iw, ih, fw, fh);
      phase++;
    end

    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
